[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/gnmd_pkg.sv]
// ----------------------------------------------------------------------------
// gnmd_pkg
// Types and codes shared by the distance map controller, datapath and checker.
// ----------------------------------------------------------------------------
package gnmd_pkg;

  // Item mode codes.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_MARK  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_HEIGHT = 2'd1;

  localparam int unsigned CFG_DATA_W = 7;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] col;
    logic [5:0] row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] distance;
    logic       is_mark;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_MARK_TAIL,
    ST_RD_WAIT,
    ST_RD_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic fill_load;
    logic clr_step;
    logic mark_start;
    logic mark_step;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_board;
    logic clr_last;
    logic mark_last;
    logic out_free;
  } status_t;

endpackage

[rtl/grid_nearest_mark_distance_map.sv]
// ----------------------------------------------------------------------------
// grid_nearest_mark_distance_map
// City-block distance map of a marked grid with clear, mark and read items.
// ----------------------------------------------------------------------------
// The block holds a MAX_DIM x MAX_DIM map of 8-bit distances in one
// single-port-write, single-port-read memory, and takes one transaction at a
// time. A clear transaction latches board_width + board_height + 1 (as used,
// saturated at 255) and writes it to every entry, one entry per cycle, so it
// keeps the input stalled until the last entry is written. A mark
// transaction inside the board reads, lowers and writes back each cell of the
// board in use, one cell per cycle through the memory's read port, and frees
// the input once the last cell is written back; a mark outside the board is
// dropped at once. A read transaction reads the memory as it is accepted,
// passes a wait state and loads the result register once that is free, and
// then frees the input. After reset the same clearing pass runs, filling
// every entry with the reset fill value; no item is accepted during it,
// while configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module grid_nearest_mark_distance_map #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input item channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gnmd_pkg::in_item_t                in_item,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output gnmd_pkg::out_item_t               out_item,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gnmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gnmd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gnmd_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Configuration registers are plain flops, so a write is always taken.
  assign cfg_ready = 1'b1;

  // The controller sequences sweeps and reads; it sees only the mode of the
  // offered item and the status flags of the datapath.
  gnmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath owns the board registers, the distance memory, the sweep
  // counters with their read-modify-write pipeline, and the result register.
  gnmd_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

[rtl/gnmd_ctrl.sv]
// ----------------------------------------------------------------------------
// gnmd_ctrl
// Sequencer for clear sweeps, mark sweeps and cell reads.
// ----------------------------------------------------------------------------
module gnmd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_mode,
  output logic              in_stall,
  input  gnmd_pkg::status_t st,
  output gnmd_pkg::cmd_t    cmd
);
  import gnmd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_CLEAR: state_nxt = ST_CLEAR;
            MODE_MARK:  state_nxt = st.in_board ? ST_MARK : ST_IDLE;
            MODE_READ:  state_nxt = ST_RD_WAIT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MARK: begin
        if (st.mark_last) state_nxt = ST_MARK_TAIL;
      end
      ST_MARK_TAIL: state_nxt = ST_IDLE;
      ST_RD_WAIT:   state_nxt = ST_RD_RESP;
      ST_RD_RESP: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_mode)
            MODE_CLEAR: cmd.fill_load  = 1'b1;
            MODE_MARK:  cmd.mark_start = st.in_board;
            MODE_READ:  cmd.rd_issue   = 1'b1;
            default:    cmd            = '0;
          endcase
        end
      end
      ST_MARK:    cmd.mark_step = 1'b1;
      ST_RD_RESP: cmd.out_load  = st.out_free;
      default:    cmd           = '0;
    endcase
  end

endmodule

[rtl/gnmd_dpath.sv]
// ----------------------------------------------------------------------------
// gnmd_dpath
// Board registers, distance store, sweep counters and result register.
// ----------------------------------------------------------------------------
module gnmd_dpath #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gnmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gnmd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  gnmd_pkg::in_item_t                  in_item,
  input  logic                                out_stall,
  output logic                                out_valid,
  output gnmd_pkg::out_item_t                 out_item,
  input  gnmd_pkg::cmd_t                      cmd,
  output gnmd_pkg::status_t                   st
);
  import gnmd_pkg::*;

  localparam int unsigned DEPTH      = MAX_DIM * MAX_DIM;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned IW         = $clog2(MAX_DIM);
  localparam int unsigned RESET_DIM  = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam int unsigned RESET_FILL = 2 * RESET_DIM + 1;

  // Board size as used: zero reads as one, oversize reads as MAX_DIM.
  function automatic logic [6:0] eff_dim(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (9'(v) > 9'(MAX_DIM)) begin
      r = 7'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [6:0]    width_r, height_r;
  logic [6:0]    w_eff, h_eff;
  logic [8:0]    fill_sum;
  logic [7:0]    fill_nxt, fill_r;
  logic [AW-1:0] clr_addr_r;
  logic [5:0]    col_r, row_r;
  logic [IW-1:0] c_r, r_r;
  logic [AW-1:0] base_r;
  logic          c_end, r_end;
  logic [8:0]    c9, r9, col9, row9, dc, dr, dsum;
  logic [7:0]    mark_d;
  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_r;
  logic [7:0]    d_r;
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          rd_inside_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra, mark_addr, rd_addr;
  logic [7:0]    mem_wd, min_val;
  logic          out_valid_r;
  out_item_t     out_item_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd64;
      height_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == REG_BOARD_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_BOARD_HEIGHT) height_r <= cfg_data;
    end
  end

  assign w_eff    = eff_dim(width_r);
  assign h_eff    = eff_dim(height_r);
  assign fill_sum = 9'(w_eff) + 9'(h_eff) + 9'd1;
  assign fill_nxt = fill_sum[8] ? 8'hFF : fill_sum[7:0];

  assign st.in_board = (7'(in_item.col) < w_eff) && (7'(in_item.row) < h_eff);

  // Clear sweep over every entry of the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 8'(RESET_FILL);
      clr_addr_r <= '0;
    end else if (cmd.fill_load) begin
      fill_r     <= fill_nxt;
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign st.clr_last = (clr_addr_r == AW'(DEPTH - 1));

  // Mark sweep over the board in use, row by row.
  assign c_end        = (9'(c_r) == 9'(w_eff) - 9'd1);
  assign r_end        = (9'(r_r) == 9'(h_eff) - 9'd1);
  assign st.mark_last = c_end && r_end;
  assign mark_addr    = base_r + AW'(c_r);

  always_ff @(posedge clk) begin
    if (cmd.mark_start) begin
      col_r  <= in_item.col;
      row_r  <= in_item.row;
      c_r    <= '0;
      r_r    <= '0;
      base_r <= '0;
    end else if (cmd.mark_step) begin
      if (c_end) begin
        c_r    <= '0;
        r_r    <= r_r + IW'(1);
        base_r <= base_r + AW'(MAX_DIM);
      end else begin
        c_r <= c_r + IW'(1);
      end
    end
  end

  assign c9     = 9'(c_r);
  assign r9     = 9'(r_r);
  assign col9   = 9'(col_r);
  assign row9   = 9'(row_r);
  assign dc     = (c9 > col9) ? (c9 - col9) : (col9 - c9);
  assign dr     = (r9 > row9) ? (r9 - row9) : (row9 - r9);
  assign dsum   = dc + dr;
  assign mark_d = dsum[8] ? 8'hFF : dsum[7:0];

  // The write of a cell follows its read in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.mark_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_step) begin
      wr_addr_r <= mark_addr;
      d_r       <= mark_d;
    end
  end

  assign min_val = (d_r < rd_data_r) ? d_r : rd_data_r;
  assign rd_addr = AW'(32'(in_item.row) * 32'(MAX_DIM) + 32'(in_item.col));

  assign mem_we = cmd.clr_step || wr_pend_r;
  assign mem_wa = cmd.clr_step ? clr_addr_r : wr_addr_r;
  assign mem_wd = cmd.clr_step ? fill_r : min_val;
  assign mem_re = cmd.mark_step || cmd.rd_issue;
  assign mem_ra = cmd.rd_issue ? rd_addr : mark_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_inside_r <= st.in_board;
  end

  // Result register.
  assign st.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.distance <= rd_inside_r ? rd_data_r : 8'd0;
      out_item_r.is_mark  <= rd_inside_r && (rd_data_r == 8'd0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/gnmd_checker.sv]
// ----------------------------------------------------------------------------
// gnmd_checker
// Port-level checks on the distance map, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gnmd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input gnmd_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input gnmd_pkg::out_item_t out_item
);
  import gnmd_pkg::*;

  `ASSERT_PROP(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `ASSERT_PROP(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_item), "result changed while stalled")
  `ASSERT_NEVER(a_mark_zero, clk, rst_n, out_valid && out_item.is_mark && (out_item.distance != 8'd0), "mark flag with nonzero distance")
  `ASSERT_PROP(a_busy_after, clk, rst_n, in_valid && !in_stall && ((in_item.mode == MODE_CLEAR) || (in_item.mode == MODE_READ)) |=> in_stall, "input not held off after clear or read")

endmodule

bind grid_nearest_mark_distance_map gnmd_checker u_gnmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the city-block distance map. A scoreboard keeps
// its own copy of the distance store and the board size, predicts every read
// result and checks it field by field as it leaves the block, while tasks
// drive directed and random clear, mark and read transactions under random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import gnmd_pkg::*;

  localparam int unsigned MAX_DIM        = 64;
  localparam int unsigned MAP_CELLS      = MAX_DIM * MAX_DIM;
  // The block has no name for the fourth mode code; it must be ignored.
  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  // A clear walks the whole store and a full-board mark as long, so
  // this covers the longest transaction that can still be running unseen.
  localparam int unsigned SETTLE_CYCLES  = MAP_CELLS + 100;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned SHOWN_LIMIT    = 10;

  typedef enum int unsigned {
    PRESSURE_NONE,
    PRESSURE_HOLD,
    PRESSURE_DRAIN
  } pressure_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the distance store and the two board registers, and
  // queues the result expected from every accepted read transaction.
  // --------------------------------------------------------------------------
  class distance_map_scoreboard;
    logic [7:0]  dist_map [MAP_CELLS];
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    out_item_t   expected_reads [$];
    int unsigned errors;
    int unsigned reads_seen;

    function new();
      width_reg  = 7'd64;
      height_reg = 7'd64;
      errors     = 0;
      reads_seen = 0;
      fill_map();
    endfunction

    // Zero counts as one, anything past MAX_DIM as MAX_DIM.
    function int unsigned used_dim(logic [6:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    // A clear fills the whole store, also cells outside the board in use.
    function void fill_map();
      int unsigned fill;
      fill = used_dim(width_reg) + used_dim(height_reg) + 1;
      if (fill > 255) fill = 255;
      foreach (dist_map[i]) dist_map[i] = fill[7:0];
    endfunction

    function void log_failure(string msg);
      errors++;
      if (errors <= SHOWN_LIMIT) $display("%s", msg);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_BOARD_WIDTH) width_reg = val;
      else if (idx == REG_BOARD_HEIGHT) height_reg = val;
    endfunction

    function void note_item(in_item_t item);
      int unsigned w;
      int unsigned h;
      int unsigned dc;
      int unsigned dr;
      int unsigned idx;
      bit          on_board;
      out_item_t   res;
      w = used_dim(width_reg);
      h = used_dim(height_reg);
      on_board = (item.col < w) && (item.row < h);
      case (item.mode)
        MODE_CLEAR: fill_map();
        MODE_MARK: begin
          // A mark off the board is dropped; otherwise only board cells drop.
          if (on_board) begin
            for (int unsigned r = 0; r < h; r++) begin
              for (int unsigned c = 0; c < w; c++) begin
                dc  = (c > item.col) ? c - item.col : item.col - c;
                dr  = (r > item.row) ? r - item.row : item.row - r;
                idx = r * MAX_DIM + c;
                if (dc + dr < dist_map[idx]) dist_map[idx] = 8'(dc + dr);
              end
            end
          end
        end
        MODE_READ: begin
          if (on_board) begin
            res.distance = dist_map[item.row * MAX_DIM + item.col];
            res.is_mark  = (res.distance == 0);
          end else begin
            res = '0;
          end
          expected_reads.push_back(res);
        end
        MODE_UNUSED: ;
        default: ;
      endcase
    endfunction

    function void check_read(out_item_t got);
      out_item_t want;
      reads_seen++;
      if (expected_reads.size() == 0) begin
        log_failure($sformatf("read result %0d unexpected: distance %0d is_mark %0d",
                              reads_seen, got.distance, got.is_mark));
        return;
      end
      want = expected_reads.pop_front();
      if (got.distance !== want.distance || got.is_mark !== want.is_mark)
        log_failure($sformatf(
          "read result %0d mismatch: distance exp %0d got %0d, is_mark exp %0d got %0d",
          reads_seen, want.distance, got.distance, want.is_mark, got.is_mark));
    endfunction

    function int unsigned pending();
      return expected_reads.size();
    endfunction

    function void flag_leftovers();
      if (expected_reads.size() != 0)
        log_failure($sformatf("%0d read results never arrived", expected_reads.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts at a known value.
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  distance_map_scoreboard sb;

  // Sender burst bookkeeping, owned by the stimulus process.
  int unsigned burst_left   = 0;
  // Long receiver hold requests: the stimulus process bumps holds_asked and
  // the receiver process catches up with holds_served.
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_style  = 0;
  int unsigned style_left   = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  grid_nearest_mark_distance_map #(
    .MAX_DIM (MAX_DIM)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Monitor. All handshakes are sampled at the rising edge, where inputs and
  // outputs still hold their values from before the edge, so the order of
  // processes within the time step does not matter. A transaction is noted
  // before a configuration write taken at the same edge, since the block
  // only uses the new register value from the next cycle on. The watchdog
  // ends the run once quiet_cycles, which counts edges since anything at all
  // was last accepted, reaches WATCHDOG_LIMIT.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_item);
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
      if (out_valid && !out_stall) sb.check_read(out_item);
    end
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Outside a long hold it switches, each time style_left runs out,
  // between never stalling, stalling now and then and stalling most of the
  // time, so stalls land on every phase of a read. A long hold keeps out_stall
  // high while hold_left, loaded with LONG_HOLD, counts down here, so the
  // result register stays full and the block has to stall its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= LONG_HOLD;
      out_stall    <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 2);
        style_left  <= $urandom_range(16, 80);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Offers one transaction and waits for the edge that takes it. Valid
  // stays high into the next transaction while a burst lasts; when the burst
  // runs out it drops for a random gap and a new burst length is drawn.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] mode, input logic [5:0] col,
                           input logic [5:0] row);
    in_item_t item;
    item.mode = mode;
    item.col  = col;
    item.row  = row;
    in_item  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Stops offering, waits until every expected read result has come back and
  // then lets extra_cycles pass so that a clear or mark still in flight ends.
  task automatic settle(input int unsigned extra_cycles);
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // Writes both board registers back to back, valid held high throughout.
  task automatic set_board(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BOARD_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_BOARD_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random phase on a fresh board size. Most transactions are reads and
  // marks on the board in use so the map fills with real distances; a fifth
  // use the full coordinate range, which mostly falls off small boards, and a
  // few carry the unused mode code. Halfway through, the chosen pressure is
  // applied: a long receiver hold while reads keep coming, or a sender pause
  // until every result is back.
  task automatic run_random_phase(input logic [CFG_DATA_W-1:0] w,
                                  input logic [CFG_DATA_W-1:0] h,
                                  input int unsigned count, input pressure_t pressure);
    int unsigned wu;
    int unsigned hu;
    int unsigned pick;
    logic [1:0]  mode;
    logic [5:0]  col;
    logic [5:0]  row;
    settle(SETTLE_CYCLES);
    set_board(w, h);
    wu = sb.used_dim(w);
    hu = sb.used_dim(h);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2 && pressure == PRESSURE_HOLD) begin
        holds_asked <= holds_asked + 1;
        repeat (6) send_item(MODE_READ, 6'($urandom_range(0, wu - 1)),
                             6'($urandom_range(0, hu - 1)));
      end
      if (n == count / 2 && pressure == PRESSURE_DRAIN) settle(0);
      pick = $urandom_range(0, 99);
      if (pick < 8)       mode = MODE_CLEAR;
      else if (pick < 38) mode = MODE_MARK;
      else if (pick < 94) mode = MODE_READ;
      else                mode = MODE_UNUSED;
      if ($urandom_range(0, 4) == 0) begin
        col = 6'($urandom_range(0, 63));
        row = 6'($urandom_range(0, 63));
      end else begin
        col = 6'($urandom_range(0, wu - 1));
        row = 6'($urandom_range(0, hu - 1));
      end
      send_item(mode, col, row);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. Reset is held low at the start; the block then runs its own
  // clearing pass and stalls the first transaction until that is done.
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset board, 64 x 64: the store holds the reset fill in the corners,
    // the unused mode code is ignored, a mark in the far corner spreads over
    // the whole board, and a clear restores the fill.
    send_item(MODE_READ, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd63, 6'd63);
    send_item(MODE_UNUSED, 6'd63, 6'd63);
    send_item(MODE_MARK, 6'd63, 6'd0);
    send_item(MODE_READ, 6'd0, 6'd63);
    send_item(MODE_READ, 6'd63, 6'd0);
    send_item(MODE_CLEAR, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd10, 6'd10);

    // A width of zero acts as one column and a height above the store size
    // as the full height. Marks and reads past the single column fall off
    // the board: the mark is dropped and the read returns zero.
    settle(SETTLE_CYCLES);
    set_board(7'd0, 7'd127);
    send_item(MODE_MARK, 6'd0, 6'd5);
    send_item(MODE_MARK, 6'd1, 6'd5);
    send_item(MODE_READ, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd1, 6'd0);
    send_item(MODE_READ, 6'd0, 6'd63);

    // Shrinking the board without a clear keeps the stored distances; the
    // following clear then fills with the small board's own value.
    settle(SETTLE_CYCLES);
    set_board(7'd5, 7'd3);
    send_item(MODE_READ, 6'd4, 6'd2);
    send_item(MODE_READ, 6'd0, 6'd2);
    send_item(MODE_CLEAR, 6'd63, 6'd63);
    send_item(MODE_READ, 6'd4, 6'd2);
    send_item(MODE_MARK, 6'd4, 6'd2);
    send_item(MODE_MARK, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd2, 6'd1);
    send_item(MODE_READ, 6'd5, 6'd0);
    send_item(MODE_READ, 6'd0, 6'd3);

    // Random phases over tiny, small, full and clamped board sizes.
    run_random_phase(7'd1, 7'd1, 20, PRESSURE_NONE);
    run_random_phase(7'($urandom_range(2, 8)), 7'($urandom_range(2, 8)), 24, PRESSURE_HOLD);
    run_random_phase(7'd64, 7'd64, 14, PRESSURE_NONE);
    run_random_phase(7'd127, 7'($urandom_range(1, 6)), 20, PRESSURE_NONE);
    run_random_phase(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 16,
                     PRESSURE_NONE);
    run_random_phase(7'($urandom_range(1, 10)), 7'($urandom_range(1, 10)), 24,
                     PRESSURE_DRAIN);

    settle(SETTLE_CYCLES);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
